// ===== src/prq_pkg.sv =====
// shared types and constants of the priority ready queue
// depends on nothing; used by the top level and the port checker
package prq_pkg;

  localparam int NUM_LEVELS  = 64;
  localparam int NUM_THREADS = 64;

  localparam int ID_W   = 6;
  localparam int PRIO_W = 6;
  localparam int IN_W   = 16;
  localparam int OUT_W  = 16;

  localparam int LVL_AW = $clog2(NUM_LEVELS);
  localparam int THR_AW = $clog2(NUM_THREADS);

  // bitmap scan works on groups of eight levels
  localparam int GROUP_W    = 8;
  localparam int GROUP_SH   = $clog2(GROUP_W);
  localparam int NUM_GROUPS = (NUM_LEVELS + GROUP_W - 1) / GROUP_W;
  localparam int GRP_W      = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
  localparam int MAP_PAD_W  = NUM_GROUPS * GROUP_W;

  typedef enum logic [1:0] {
    OP_ADD_HEAD = 2'd0,
    OP_ADD_TAIL = 2'd1,
    OP_REMOVE   = 2'd2,
    OP_CHOOSE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK          = 2'd0,
    STAT_ADD_REFUSED = 2'd1,
    STAT_NOT_FOUND   = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_FIX_PREV,
    S_FIX_NEXT,
    S_MID_A,
    S_MID_B,
    S_SCAN,
    S_FINISH
  } state_t;

  // input item as packed on tdata, lowest field last
  typedef struct packed {
    logic              pad;
    logic              is_ready;
    logic [PRIO_W-1:0] priority_req;
    logic [ID_W-1:0]   thread_id;
    op_t               opcode;
  } in_item_t;

  // result item as packed on tdata, lowest field last
  typedef struct packed {
    logic [PRIO_W-1:0] top_priority;
    logic              top_valid;
    logic [ID_W-1:0]   chosen_thread;
    logic              chosen_valid;
    status_t           status;
  } out_item_t;

  // per level entry
  typedef struct packed {
    logic [ID_W-1:0] head;
    logic [ID_W-1:0] tail;
  } lvl_ent_t;

  // per thread entry
  typedef struct packed {
    logic              inq;
    logic [PRIO_W-1:0] lvl;
    logic [ID_W-1:0]   prev;
    logic [ID_W-1:0]   nxt;
  } thr_ent_t;

endpackage

// ===== src/prq_ram.sv =====
// generic single write, single read synchronous ram with registered read data
// depends on nothing
module prq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/priority_ready_queue.sv =====
// priority ready queue: per level doubly linked thread lists kept in two rams
// depends on prq_pkg and prq_ram
//
// one request item in, one result item out. an item is accepted in the cycle the
// block is idle or delivering the previous result; the sequencer reads the level
// ram and the thread ram in that cycle and modifies and writes them back after.
// choose, refused requests, adds of a queued thread, adds to an empty list and
// removes at the head or the tail go straight on to the result; an add to a
// non-empty list first fixes the neighbour's link through the single thread ram
// port; a remove from the middle of a list fixes both neighbours in turn; a remove
// that empties a list finds the top again by scanning the bitmap eight levels a
// cycle from the highest group down. after reset a clearing pass marks every
// thread as not queued; no item is accepted then. a finished result sits in the
// output register, so a new item is taken while the previous result still waits
module priority_ready_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // opcode, thread_id, priority_req, is_ready, zero pad
  input  logic [prq_pkg::IN_W-1:0]  s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // status, chosen_valid, chosen_thread, top_valid, top_priority
  output logic [prq_pkg::OUT_W-1:0] m_axis_tdata
);

  import prq_pkg::*;

  // highest set bit within one group of the bitmap
  function automatic logic [GROUP_SH-1:0] fls_group(input logic [GROUP_W-1:0] b);
    logic [GROUP_SH-1:0] r;
    r = '0;
    for (int i = 0; i < GROUP_W; i++) begin
      if (b[i]) begin
        r = GROUP_SH'(i);
      end
    end
    return r;
  endfunction

  // sequencer
  state_t state, state_next;

  // control registers
  logic [THR_AW-1:0]     clr_idx, clr_idx_next;
  logic [NUM_LEVELS-1:0] nonempty_map, nonempty_map_next;
  logic [PRIO_W-1:0]     top_level, top_level_next;
  logic                  top_present, top_present_next;
  logic                  out_valid;
  out_item_t             out_data;

  // request and working registers
  op_t               req_op;
  logic [ID_W-1:0]   req_tid;
  logic [PRIO_W-1:0] req_lv;
  logic              req_rdy;
  logic [ID_W-1:0]   link_a, link_a_next;
  logic [ID_W-1:0]   link_b, link_b_next;
  status_t           res_status, res_status_next;
  logic              res_cvalid, res_cvalid_next;
  logic [ID_W-1:0]   res_cthread, res_cthread_next;
  logic [GRP_W-1:0]  grp, grp_next;

  // ram ports
  logic              t_we, l_we;
  logic [THR_AW-1:0] t_waddr, t_raddr;
  logic [LVL_AW-1:0] l_waddr, l_raddr;
  thr_ent_t          t_wdata, t_rd;
  lvl_ent_t          l_wdata, l_rd;
  logic [$bits(thr_ent_t)-1:0] t_rdata;
  logic [$bits(lvl_ent_t)-1:0] l_rdata;

  // decoded request
  in_item_t              in_item;
  logic                  accept;
  logic                  out_free;
  logic                  ids_ok;
  logic [LVL_AW-1:0]     lv_idx;
  logic                  lv_busy;
  logic                  add_ok;
  logic                  rm_ok;
  logic                  is_head;
  logic                  is_tail;
  logic [MAP_PAD_W-1:0]  map_pad;
  logic [GROUP_W-1:0]    grp_bits;
  logic                  grp_hit;

  assign in_item  = in_item_t'(s_axis_tdata);
  assign accept   = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid || m_axis_tready;

  assign t_rd = thr_ent_t'(t_rdata);
  assign l_rd = lvl_ent_t'(l_rdata);

  // ids beyond the configured tables are refused
  assign ids_ok  = (32'(req_tid) < NUM_THREADS) && (32'(req_lv) < NUM_LEVELS);
  assign lv_idx  = LVL_AW'(req_lv);
  assign lv_busy = nonempty_map[lv_idx];
  assign add_ok  = req_rdy && ids_ok;
  // remove needs the thread queued at the level it names
  assign rm_ok   = req_rdy && ids_ok && t_rd.inq && (t_rd.lvl == req_lv);
  assign is_head = (l_rd.head == req_tid);
  assign is_tail = (l_rd.tail == req_tid);

  // bitmap scan, one group a cycle
  assign map_pad  = MAP_PAD_W'(nonempty_map);
  assign grp_bits = map_pad[grp*GROUP_W +: GROUP_W];
  assign grp_hit  = |grp_bits;

  // level ram: head and tail per level
  prq_ram #(
    .WIDTH ($bits(lvl_ent_t)),
    .DEPTH (NUM_LEVELS)
  ) u_lvl_ram (
    .clk   (clk),
    .we    (l_we),
    .waddr (l_waddr),
    .wdata (l_wdata),
    .raddr (l_raddr),
    .rdata (l_rdata)
  );

  // thread ram: links, queued level and membership per thread
  prq_ram #(
    .WIDTH ($bits(thr_ent_t)),
    .DEPTH (NUM_THREADS)
  ) u_thr_ram (
    .clk   (clk),
    .we    (t_we),
    .waddr (t_waddr),
    .wdata (t_wdata),
    .raddr (t_raddr),
    .rdata (t_rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (clr_idx == THR_AW'(NUM_THREADS - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_FINISH;
        unique case (req_op)
          OP_ADD_HEAD: begin
            if (add_ok && !t_rd.inq && lv_busy) begin
              state_next = S_FIX_PREV;
            end
          end
          OP_ADD_TAIL: begin
            if (add_ok && !t_rd.inq && lv_busy) begin
              state_next = S_FIX_NEXT;
            end
          end
          OP_REMOVE: begin
            if (rm_ok && is_head && is_tail) begin
              state_next = S_SCAN;
            end else if (rm_ok && !is_head && !is_tail) begin
              state_next = S_MID_A;
            end
          end
          OP_CHOOSE: begin
            state_next = S_FINISH;
          end
          default: begin
            state_next = S_FINISH;
          end
        endcase
      end
      S_FIX_PREV, S_FIX_NEXT, S_MID_B: begin
        state_next = S_FINISH;
      end
      S_MID_A: begin
        state_next = S_MID_B;
      end
      S_SCAN: begin
        if (grp_hit || (grp == '0)) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          state_next = accept ? S_EXEC : S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // handshake
  always_comb begin
    s_axis_tready = (state == S_IDLE) || ((state == S_FINISH) && out_free);
  end

  // ram accesses and working register updates
  always_comb begin
    clr_idx_next      = clr_idx;
    nonempty_map_next = nonempty_map;
    top_level_next    = top_level;
    top_present_next  = top_present;
    link_a_next       = link_a;
    link_b_next       = link_b;
    res_status_next   = res_status;
    res_cvalid_next   = res_cvalid;
    res_cthread_next  = res_cthread;
    grp_next          = grp;

    // reads for a newly accepted item
    t_raddr = THR_AW'(in_item.thread_id);
    l_raddr = (in_item.opcode == OP_CHOOSE) ? LVL_AW'(top_level)
                                            : LVL_AW'(in_item.priority_req);
    t_we    = 1'b0;
    t_waddr = THR_AW'(req_tid);
    t_wdata = t_rd;
    l_we    = 1'b0;
    l_waddr = lv_idx;
    l_wdata = l_rd;

    unique case (state)
      S_CLEAR: begin
        // mark every thread as not queued
        t_we         = 1'b1;
        t_waddr      = clr_idx;
        t_wdata      = '0;
        clr_idx_next = clr_idx + 1'b1;
      end
      S_EXEC: begin
        res_status_next  = STAT_OK;
        res_cvalid_next  = 1'b0;
        res_cthread_next = '0;
        unique case (req_op)
          OP_ADD_HEAD, OP_ADD_TAIL: begin
            if (!add_ok) begin
              res_status_next = STAT_ADD_REFUSED;
            end else if (!t_rd.inq) begin
              t_we = 1'b1;
              l_we = 1'b1;
              if (!lv_busy) begin
                // first thread of this level
                l_wdata = '{head: req_tid, tail: req_tid};
                t_wdata = '{inq: 1'b1, lvl: req_lv, prev: '0, nxt: '0};
                nonempty_map_next[lv_idx] = 1'b1;
                if (!top_present || (top_level < req_lv)) begin
                  top_level_next   = req_lv;
                  top_present_next = 1'b1;
                end
              end else if (req_op == OP_ADD_HEAD) begin
                l_wdata     = '{head: req_tid, tail: l_rd.tail};
                t_wdata     = '{inq: 1'b1, lvl: req_lv, prev: '0, nxt: l_rd.head};
                t_raddr     = THR_AW'(l_rd.head);
                link_a_next = l_rd.head;
              end else begin
                l_wdata     = '{head: l_rd.head, tail: req_tid};
                t_wdata     = '{inq: 1'b1, lvl: req_lv, prev: l_rd.tail, nxt: '0};
                t_raddr     = THR_AW'(l_rd.tail);
                link_a_next = l_rd.tail;
              end
            end
          end
          OP_REMOVE: begin
            if (!rm_ok) begin
              res_status_next = STAT_NOT_FOUND;
            end else begin
              t_we        = 1'b1;
              t_wdata     = t_rd;
              t_wdata.inq = 1'b0;
              if (is_head && is_tail) begin
                // list empties: clear its bit and rescan from the top group
                nonempty_map_next[lv_idx] = 1'b0;
                grp_next = GRP_W'(NUM_GROUPS - 1);
              end else if (is_head) begin
                l_we    = 1'b1;
                l_wdata = '{head: t_rd.nxt, tail: l_rd.tail};
              end else if (is_tail) begin
                l_we    = 1'b1;
                l_wdata = '{head: l_rd.head, tail: t_rd.prev};
              end else begin
                t_raddr     = THR_AW'(t_rd.prev);
                link_a_next = t_rd.prev;
                link_b_next = t_rd.nxt;
              end
            end
          end
          OP_CHOOSE: begin
            res_cvalid_next  = top_present;
            res_cthread_next = top_present ? l_rd.head : '0;
          end
          default: begin
            res_status_next = STAT_OK;
          end
        endcase
      end
      S_FIX_PREV: begin
        // old head now points back at the new head
        t_we    = 1'b1;
        t_waddr = THR_AW'(link_a);
        t_wdata = '{inq: t_rd.inq, lvl: t_rd.lvl, prev: req_tid, nxt: t_rd.nxt};
      end
      S_FIX_NEXT: begin
        // old tail now points on to the new tail
        t_we    = 1'b1;
        t_waddr = THR_AW'(link_a);
        t_wdata = '{inq: t_rd.inq, lvl: t_rd.lvl, prev: t_rd.prev, nxt: req_tid};
      end
      S_MID_A: begin
        // predecessor skips the removed thread, then fetch the successor
        t_we    = 1'b1;
        t_waddr = THR_AW'(link_a);
        t_wdata = '{inq: t_rd.inq, lvl: t_rd.lvl, prev: t_rd.prev, nxt: link_b};
        t_raddr = THR_AW'(link_b);
      end
      S_MID_B: begin
        t_we    = 1'b1;
        t_waddr = THR_AW'(link_b);
        t_wdata = '{inq: t_rd.inq, lvl: t_rd.lvl, prev: link_a, nxt: t_rd.nxt};
      end
      S_SCAN: begin
        if (grp_hit) begin
          top_level_next   = PRIO_W'({grp, fls_group(grp_bits)});
          top_present_next = 1'b1;
        end else if (grp == '0) begin
          top_level_next   = '0;
          top_present_next = 1'b0;
        end else begin
          grp_next = grp - 1'b1;
        end
      end
      S_IDLE, S_FINISH: begin
        clr_idx_next = clr_idx;
      end
      default: begin
        clr_idx_next = clr_idx;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_idx      <= '0;
      nonempty_map <= '0;
      top_level    <= '0;
      top_present  <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      clr_idx      <= clr_idx_next;
      nonempty_map <= nonempty_map_next;
      top_level    <= top_level_next;
      top_present  <= top_present_next;
      if ((state == S_FINISH) && out_free) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload and working registers
  always_ff @(posedge clk) begin
    if (accept) begin
      req_op  <= in_item.opcode;
      req_tid <= in_item.thread_id;
      req_lv  <= in_item.priority_req;
      req_rdy <= in_item.is_ready;
    end
    link_a      <= link_a_next;
    link_b      <= link_b_next;
    res_status  <= res_status_next;
    res_cvalid  <= res_cvalid_next;
    res_cthread <= res_cthread_next;
    grp         <= grp_next;
    // result item carries the top as it stands after the request
    if ((state == S_FINISH) && out_free) begin
      out_data.status        <= res_status;
      out_data.chosen_valid  <= res_cvalid;
      out_data.chosen_thread <= res_cthread;
      out_data.top_valid     <= top_present;
      out_data.top_priority  <= top_present ? top_level : '0;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

endmodule

// ===== src/prq_checker.sv =====
// port level checks of the priority ready queue, bound to the top level
// depends on prq_pkg and priority_ready_queue
module prq_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      s_axis_tready,
  input logic                      m_axis_tvalid,
  input logic                      m_axis_tready,
  input logic [prq_pkg::OUT_W-1:0] m_axis_tdata
);

  import prq_pkg::*;

  out_item_t res;

  assign res = out_item_t'(m_axis_tdata);

  // a stalled result item holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result item changed while stalled");

  // no item taken as the clearing pass after reset begins
  a_clear_pass: assert property (@(posedge clk) disable iff (rst)
    $fell(rst) |-> !s_axis_tready)
    else $error("item accepted during clearing pass");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (res.status == STAT_OK || res.status == STAT_ADD_REFUSED ||
                       res.status == STAT_NOT_FOUND))
    else $error("status code out of range");

  // empty queue reports level zero, failed choose reports thread zero
  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (res.top_valid || res.top_priority == '0) &&
                      (res.chosen_valid || res.chosen_thread == '0))
    else $error("invalid field not zero");

  // a chosen thread implies a non-empty queue and a clean status
  a_chosen_top: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && res.chosen_valid |-> res.top_valid && res.status == STAT_OK)
    else $error("chosen thread without a top level");

endmodule

bind priority_ready_queue prq_checker u_prq_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
